>>> hw/rtl/bary_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bary_pkg
// Shared constants and register codes for the barycentric triangle mapper.
// ----------------------------------------------------------------------------
package bary_pkg;

  // default coordinate width (signed fixed point)
  localparam int COORD_BITS_DEF       = 16;
  // default fractional bits of a blend weight
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  // integer bits of a blend weight; larger quotients clip to all ones
  localparam int WEIGHT_INT_BITS      = 17;
  // width of the configuration register index
  localparam int CFG_IDX_BITS         = 3;

  // configuration register index
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAP_A = 3'd0,
    REG_MAP_B = 3'd1,
    REG_MAP_C = 3'd2,
    REG_POS_A = 3'd3,
    REG_POS_B = 3'd4,
    REG_POS_C = 3'd5
  } cfg_reg_e;

endpackage

>>> hw/rtl/barycentric_triangle_mapping.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_triangle_mapping
// Maps a 2D point through a configured 2D/3D triangle pair using
// barycentric weights, with rounding and saturation to signed fixed point.
// ----------------------------------------------------------------------------
// Channel   | Direction | Content
// s_axis    | in        | tdata: point_x, point_y
// m_axis    | out       | tdata: out_x, out_y, out_z; tuser: degenerate, saturated
// cfg       | in        | cfg_we_i / cfg_idx_i / cfg_data_i register writes
//
// One point enters per cycle while s_axis_tready is high; the pipelined
// restoring divider computes one quotient bit per stage.
// rst_ni clears valid bits and configuration.
// A stalled output parks one beat in a skid register; the pipeline then
// freezes as a whole and s_axis_tready drops until the skid drains.
// ----------------------------------------------------------------------------
module barycentric_triangle_mapping #(
  parameter int COORD_BITS       = bary_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = bary_pkg::WEIGHT_FRAC_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bary_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [3*COORD_BITS-1:0]           cfg_data_i,
  // input points
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,   // point_x, point_y
  // mapped results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_W-1:0]                  m_axis_tdata,   // out_x, out_y, out_z
  output logic [1:0]                        m_axis_tuser    // degenerate, saturated
);

  localparam int CB  = COORD_BITS;
  localparam int WF  = WEIGHT_FRAC_BITS;
  localparam int WIB = bary_pkg::WEIGHT_INT_BITS;
  localparam int DW  = CB + 1;          // coordinate difference
  localparam int PW  = 2 * DW;          // difference product
  localparam int XW  = PW + 1;          // cross product
  localparam int AW  = 2 * CB + 1;      // absolute cross product
  localparam int QW  = WF + WIB;        // weight
  localparam int MW  = QW + 1 + CB;     // weight times coordinate
  localparam int SW  = MW + 2;          // sum of three products
  localparam int NS  = QW + 8;          // stages carrying a valid bit
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (WF - 1);
  localparam logic signed [SW-1:0] HI   = SW'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic signed [SW-1:0] LO   = -HI - SW'(1);

  // configuration registers
  logic [2*CB-1:0] map_q [3];
  logic [3*CB-1:0] pos_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        map_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bary_pkg::REG_MAP_A: map_q[0] <= cfg_data_i[2*CB-1:0];
        bary_pkg::REG_MAP_B: map_q[1] <= cfg_data_i[2*CB-1:0];
        bary_pkg::REG_MAP_C: map_q[2] <= cfg_data_i[2*CB-1:0];
        bary_pkg::REG_POS_A: pos_q[0] <= cfg_data_i;
        bary_pkg::REG_POS_B: pos_q[1] <= cfg_data_i;
        bary_pkg::REG_POS_C: pos_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic signed [DW-1:0] diff(input logic [CB-1:0] a,
                                                input logic [CB-1:0] b);
    diff = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
  endfunction

  logic [CB-1:0] ax, ay, bx, by, cx, cy;
  assign ax = map_q[0][CB-1:0];
  assign ay = map_q[0][2*CB-1:CB];
  assign bx = map_q[1][CB-1:0];
  assign by = map_q[1][2*CB-1:CB];
  assign cx = map_q[2][CB-1:0];
  assign cy = map_q[2][2*CB-1:CB];

  // full triangle area, tracks configuration in three steps
  logic signed [PW-1:0] fm0_q, fm1_q;
  logic signed [XW-1:0] fx_q;
  logic [AW-1:0]        full_q;

  always_ff @(posedge clk_i) begin
    fm0_q  <= diff(bx, ax) * diff(cy, ay);
    fm1_q  <= diff(cx, ax) * diff(by, ay);
    fx_q   <= XW'(fm0_q) - XW'(fm1_q);
    full_q <= fx_q[XW-1] ? AW'(-fx_q) : AW'(fx_q);
  end

  // global advance: freeze everything while the skid holds a beat
  logic skid_v_q, out_v_q, en;
  logic [NS-1:0] vld_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  // datapath registers
  logic [CB-1:0]        px_q, py_q;
  logic signed [PW-1:0] m0_q [3];
  logic signed [PW-1:0] m1_q [3];
  logic signed [XW-1:0] cx_q [3];
  logic [AW-1:0]        sub_q [3];
  logic [AW-1:0]        dr_q  [QW+1][3];
  logic [QW-1:0]        dnq_q [QW+1][3];
  logic                 dov_q [QW+1][3];
  logic signed [MW-1:0] pr_q  [3][3];
  logic signed [SW-1:0] sm_q  [3];
  logic [CB-1:0]        rc_q  [3];
  logic                 rsat_q, rdeg_q;

  // one divider step: bring in next dividend bit, subtract if it fits
  logic [AW:0]   st_t [QW][3];
  logic          st_ge [QW][3];
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < 3; l++) begin
        st_t[j][l]  = {dr_q[j][l], dnq_q[j][l][QW-1]};
        st_ge[j][l] = st_t[j][l] >= {1'b0, full_q};
      end
    end
  end

  // round, saturate and flag
  logic signed [SW-1:0] rt [3];
  logic signed [SW-1:0] rq [3];
  logic [2:0]           rclip;
  logic [CB-1:0]        rval [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rt[k] = sm_q[k] + HALF;
      rq[k] = rt[k] >>> WF;
      if (rq[k] > HI) begin
        rval[k]  = HI[CB-1:0];
        rclip[k] = 1'b1;
      end else if (rq[k] < LO) begin
        rval[k]  = LO[CB-1:0];
        rclip[k] = 1'b1;
      end else begin
        rval[k]  = rq[k][CB-1:0];
        rclip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // capture the point
      px_q <= s_axis_tdata[CB-1:0];
      py_q <= s_axis_tdata[2*CB-1:CB];
      // sub-triangle difference products
      m0_q[0] <= diff(bx, px_q) * diff(cy, py_q);
      m1_q[0] <= diff(cx, px_q) * diff(by, py_q);
      m0_q[1] <= diff(px_q, ax) * diff(cy, ay);
      m1_q[1] <= diff(cx, ax) * diff(py_q, ay);
      m0_q[2] <= diff(bx, ax) * diff(py_q, ay);
      m1_q[2] <= diff(px_q, ax) * diff(by, ay);
      for (int l = 0; l < 3; l++) begin
        // cross products and their magnitudes
        cx_q[l]  <= XW'(m0_q[l]) - XW'(m1_q[l]);
        sub_q[l] <= cx_q[l][XW-1] ? AW'(-cx_q[l]) : AW'(cx_q[l]);
        // seed divider with the high dividend part, flag quotient overflow
        dr_q[0][l]  <= AW'(sub_q[l] >> WIB);
        dnq_q[0][l] <= QW'({sub_q[l], {WF{1'b0}}});
        dov_q[0][l] <= AW'(sub_q[l] >> WIB) >= full_q;
        // divider stages
        for (int j = 0; j < QW; j++) begin
          dr_q[j+1][l]  <= st_ge[j][l] ? AW'(st_t[j][l] - {1'b0, full_q})
                                       : st_t[j][l][AW-1:0];
          dnq_q[j+1][l] <= {dnq_q[j][l][QW-2:0], st_ge[j][l]};
          dov_q[j+1][l] <= dov_q[j][l];
        end
      end
      // weight times vertex coordinate
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          pr_q[k][l] <= $signed({1'b0, (dov_q[QW][l] ? {QW{1'b1}} : dnq_q[QW][l])})
                        * $signed(pos_q[l][k*CB +: CB]);
        end
        sm_q[k] <= SW'(pr_q[k][0]) + SW'(pr_q[k][1]) + SW'(pr_q[k][2]);
      end
      // final values, zeroed for a flat triangle
      rdeg_q <= full_q == '0;
      rsat_q <= (full_q != '0) && (rclip != '0);
      for (int k = 0; k < 3; k++) begin
        rc_q[k] <= (full_q == '0) ? '0 : rval[k];
      end
    end
  end

  // output register with skid
  logic [CB-1:0] oc_q [3];
  logic [CB-1:0] kc_q [3];
  logic          odeg_q, osat_q, kdeg_q, ksat_q;
  logic          pipe_v;
  assign pipe_v = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || pipe_v;
      skid_v_q <= 1'b0;
    end else if (pipe_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        oc_q   <= kc_q;
        odeg_q <= kdeg_q;
        osat_q <= ksat_q;
      end else begin
        oc_q   <= rc_q;
        odeg_q <= rdeg_q;
        osat_q <= rsat_q;
      end
    end else if (en) begin
      kc_q   <= rc_q;
      kdeg_q <= rdeg_q;
      ksat_q <= rsat_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({oc_q[2], oc_q[1], oc_q[0]});
  assign m_axis_tuser  = {osat_q, odeg_q};

  // skid fills only behind a held output beat
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while output is empty");

  // flat triangle gives zero coordinates and no clip flag
  a_degenerate_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("degenerate result carries data");

  // input back-pressure only follows an output stall
  a_ready_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

endmodule
